@@ sv/two_class_request_queue_macros.svh @@
// Assertion helpers for the request queue
`ifndef TWO_CLASS_REQUEST_QUEUE_MACROS_SVH
`define TWO_CLASS_REQUEST_QUEUE_MACROS_SVH

// same-cycle implication
`define TCRQ_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCRQ_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/tcrq_pkg.sv @@
`default_nettype none

package tcrq_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int NUM_SERVICES_DEF = 4;

    localparam int TAG_W = 8;
    localparam int AGE_W = 7;
    localparam int REQ_W = 4;
    localparam int SVC_W = 2;
    localparam int OP_W  = 2;

    localparam logic [AGE_W-1:0] PRIORITY_AGE_RST = AGE_W'(60);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_SERVE = 2'd1,
        OP_FAST  = 2'd2
    } op_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [TAG_W-1:0] tag;
        logic [AGE_W-1:0] age;
        logic [REQ_W-1:0] req;
        logic [SVC_W-1:0] svc;
    } cmd_t;

    typedef struct packed {
        logic             hit_before;
        logic             rm_before;
        logic [TAG_W-1:0] tag;
    } chain_t;

endpackage

`default_nettype wire

@@ sv/tcrq_cell.sv @@
`default_nettype none

module tcrq_cell #(
    parameter int NUM_SERVICES = tcrq_pkg::NUM_SERVICES_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          upd,
    input  wire tcrq_pkg::cmd_t                cmd,
    input  wire logic [tcrq_pkg::AGE_W-1:0]    thr,
    input  wire logic                          occupied,
    input  wire logic                          at_tail,
    input  wire logic [tcrq_pkg::TAG_W-1:0]    left_tag,
    input  wire logic [tcrq_pkg::AGE_W-1:0]    left_age,
    input  wire logic [NUM_SERVICES-1:0]       left_mask,
    input  wire logic [tcrq_pkg::TAG_W-1:0]    right_tag,
    input  wire logic [tcrq_pkg::AGE_W-1:0]    right_age,
    input  wire logic [NUM_SERVICES-1:0]       right_mask,
    input  wire tcrq_pkg::chain_t              chain_in,
    output tcrq_pkg::chain_t                   chain_out,
    output logic [tcrq_pkg::TAG_W-1:0]         tag,
    output logic [tcrq_pkg::AGE_W-1:0]         age,
    output logic [NUM_SERVICES-1:0]            mask
);
    import tcrq_pkg::*;

    logic [TAG_W-1:0]              tag_reg, tag_next;
    logic [AGE_W-1:0]              age_reg, age_next;
    logic [NUM_SERVICES-1:0]       mask_reg, mask_next;
    logic [NUM_SERVICES+REQ_W-1:0] req_ext;
    logic [NUM_SERVICES-1:0]       new_mask;
    logic [NUM_SERVICES-1:0]       sel;
    logic [NUM_SERVICES-1:0]       cleared;
    logic                          hit;
    logic                          first;
    logic                          leave;

    assign req_ext  = {{NUM_SERVICES{1'b0}}, cmd.req};
    assign new_mask = req_ext[NUM_SERVICES-1:0];
    assign cleared  = mask_reg & ~sel;

    always_comb begin
        for (int b = 0; b < NUM_SERVICES; b++) begin
            sel[b] = (int'(cmd.svc) == b);
        end
    end

    always_comb begin
        unique case (cmd.op)
            OP_ADD:   hit = occupied && (cmd.age >= thr) && (age_reg < thr);
            OP_SERVE: hit = occupied && ((mask_reg & sel) != '0);
            OP_FAST:  hit = occupied && (mask_reg != '0)
                            && ((mask_reg & (mask_reg - 1'b1)) == '0);
            default:  hit = 1'b0;
        endcase
    end

    assign first = hit && !chain_in.hit_before;
    assign leave = first && ((cmd.op == OP_FAST)
                   || ((cmd.op == OP_SERVE) && (cleared == '0)));

    assign chain_out.hit_before = chain_in.hit_before || hit;
    assign chain_out.rm_before  = chain_in.rm_before || leave;
    assign chain_out.tag        = first ? tag_reg : chain_in.tag;

    always_comb begin
        tag_next  = tag_reg;
        age_next  = age_reg;
        mask_next = mask_reg;
        unique case (cmd.op) inside
            OP_ADD: begin
                if (chain_in.hit_before && (occupied || at_tail)) begin
                    tag_next  = left_tag;
                    age_next  = left_age;
                    mask_next = left_mask;
                end else if (first || at_tail) begin
                    tag_next  = cmd.tag;
                    age_next  = cmd.age;
                    mask_next = new_mask;
                end
            end
            OP_SERVE, OP_FAST: begin
                if (occupied && chain_out.rm_before) begin
                    tag_next  = right_tag;
                    age_next  = right_age;
                    mask_next = right_mask;
                end else if (first) begin
                    mask_next = cleared;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (upd) begin
            tag_reg  <= tag_next;
            age_reg  <= age_next;
            mask_reg <= mask_next;
        end
    end

    assign tag  = tag_reg;
    assign age  = age_reg;
    assign mask = mask_reg;

endmodule

`default_nettype wire

@@ sv/two_class_request_queue.sv @@
// Channel   Direction  Payload (lowest bit first)
// s_        in         tuser: op; tdata: entry_tag, entry_age, request_mask, service
// m_        out        tdata: found, served_tag, left_queue, add_dropped, occupancy
// cfg_      in         data: priority_age
//
// Each transaction is first taken into the command register; then every cell
// of the chain decides its match, the first-match and removal chains settle and
// all cells shift or update together.
// A result waits in the output register; the next command is taken meanwhile
// but is processed only once that result has gone.
// Reset empties the queue and restores priority_age to 60; slot contents stay.
`default_nettype none

`include "two_class_request_queue_macros.svh"

module two_class_request_queue #(
    parameter int DEPTH        = tcrq_pkg::DEPTH_DEF,
    parameter int NUM_SERVICES = tcrq_pkg::NUM_SERVICES_DEF,
    parameter int CNT_W        = $clog2(DEPTH + 1),
    parameter int OUT_W        = ((tcrq_pkg::TAG_W + 3 + CNT_W + 7) / 8) * 8
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    input  wire logic [23:0]                 s_tdata,  // entry_tag, entry_age,
                                                       // request_mask, service
    input  wire logic [tcrq_pkg::OP_W-1:0]   s_tuser,  // op
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [OUT_W-1:0]                 m_tdata,  // found, served_tag, left_queue,
                                                       // add_dropped, occupancy
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [tcrq_pkg::AGE_W-1:0]  cfg_data
);
    import tcrq_pkg::*;

    localparam int RES_W = TAG_W + 3 + CNT_W;

    logic                    busy_reg, busy_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [AGE_W-1:0]        thr_reg, thr_next;
    cmd_t                    cmd_reg, cmd_next;

    logic                    s_acc;
    logic                    fire;
    logic                    full;
    logic                    is_add;
    logic                    is_match_op;
    logic                    upd;
    logic                    found;
    logic                    left_q;
    logic                    dropped;
    logic [TAG_W-1:0]        served_tag;
    logic [RES_W-1:0]        res;

    chain_t                  chain [DEPTH+1];
    logic [TAG_W-1:0]        tag_w  [DEPTH];
    logic [AGE_W-1:0]        age_w  [DEPTH];
    logic [NUM_SERVICES-1:0] mask_w [DEPTH];

    assign s_tready  = !busy_reg;
    assign cfg_ready = 1'b1;
    assign s_acc     = s_tvalid && s_tready;
    assign fire      = busy_reg && (!m_tvalid_reg || m_tready);
    assign full      = (cnt_reg == CNT_W'(DEPTH));
    assign is_add    = (cmd_reg.op == OP_ADD);
    assign is_match_op = (cmd_reg.op == OP_SERVE) || (cmd_reg.op == OP_FAST);
    assign upd       = fire && !(is_add && full);

    assign chain[0] = '0;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [TAG_W-1:0]        lt, rt;
        logic [AGE_W-1:0]        la, ra;
        logic [NUM_SERVICES-1:0] lm, rm;

        if (i == 0) begin : g_first
            assign lt = cmd_reg.tag;
            assign la = cmd_reg.age;
            assign lm = mask_w[0];
        end else begin : g_mid
            assign lt = tag_w[i-1];
            assign la = age_w[i-1];
            assign lm = mask_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign rt = tag_w[i];
            assign ra = age_w[i];
            assign rm = mask_w[i];
        end else begin : g_inner
            assign rt = tag_w[i+1];
            assign ra = age_w[i+1];
            assign rm = mask_w[i+1];
        end

        tcrq_cell #(
            .NUM_SERVICES(NUM_SERVICES)
        ) u_cell (
            .aclk      (aclk),
            .upd       (upd),
            .cmd       (cmd_reg),
            .thr       (thr_reg),
            .occupied  (cnt_reg > CNT_W'(i)),
            .at_tail   (cnt_reg == CNT_W'(i)),
            .left_tag  (lt),
            .left_age  (la),
            .left_mask (lm),
            .right_tag (rt),
            .right_age (ra),
            .right_mask(rm),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1]),
            .tag       (tag_w[i]),
            .age       (age_w[i]),
            .mask      (mask_w[i])
        );
    end

    assign found      = is_match_op && chain[DEPTH].hit_before;
    assign served_tag = is_match_op ? chain[DEPTH].tag : '0;
    assign left_q     = is_match_op && chain[DEPTH].rm_before;
    assign dropped    = is_add && full;

    always_comb begin
        cnt_next = cnt_reg;
        if (fire) begin
            if (is_add && !full) begin
                cnt_next = cnt_reg + 1'b1;
            end else if (left_q) begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    assign res = {cnt_next, dropped, left_q, served_tag, found};

    always_comb begin
        busy_next     = busy_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        cmd_next      = cmd_reg;
        thr_next      = thr_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (fire) begin
            busy_next     = 1'b0;
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_W'(res);
        end
        if (s_acc) begin
            busy_next    = 1'b1;
            cmd_next.op  = s_tuser;
            cmd_next.tag = s_tdata[7:0];
            cmd_next.age = s_tdata[14:8];
            cmd_next.req = s_tdata[18:15];
            cmd_next.svc = s_tdata[20:19];
        end
        if (cfg_valid && cfg_ready) begin
            thr_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            cnt_reg      <= '0;
            thr_reg      <= PRIORITY_AGE_RST;
        end else begin
            busy_reg     <= busy_next;
            m_tvalid_reg <= m_tvalid_next;
            cnt_reg      <= cnt_next;
            thr_reg      <= thr_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        cmd_reg     <= cmd_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TCRQ_ASSERT_IMP(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= CNT_W'(DEPTH),
        "count above depth")
    `TCRQ_ASSERT_IMP(a_left_found, aclk, aresetn, fire && left_q, found,
        "removal without match")
    `TCRQ_ASSERT_NXT(a_add_grow, aclk, aresetn, fire && is_add && !full,
        cnt_reg == $past(cnt_reg) + 1'b1, "add did not grow queue")
    `TCRQ_ASSERT_NXT(a_fire_result, aclk, aresetn, fire, m_tvalid && !busy_reg,
        "result not presented")
    `TCRQ_ASSERT_IMP(a_add_no_match, aclk, aresetn, fire && is_add, !found && !left_q,
        "add reported a match")

endmodule

`default_nettype wire
